// File: src/iase_pkg.sv
// Shared constants, command and status codes, and the sequencer state type
// for the indexed array store engine. No dependencies.
package iase_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int CMD_W    = 4;
   localparam int POS_W    = 8;
   localparam int WORD_W   = 32;
   localparam int STAT_W   = 3;
   localparam int FIDX_W   = 6;
   localparam int COUNT_W  = 7;
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam int REQ_W    = 48;
   localparam int RSP_W    = 48;

   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 4'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 4'd1;
   localparam logic [CMD_W-1:0] CMD_INSERT     = 4'd2;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 4'd3;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 4'd4;
   localparam logic [CMD_W-1:0] CMD_REMOVE     = 4'd5;
   localparam logic [CMD_W-1:0] CMD_GET        = 4'd6;
   localparam logic [CMD_W-1:0] CMD_SET        = 4'd7;
   localparam logic [CMD_W-1:0] CMD_SEARCH     = 4'd8;
   localparam logic [CMD_W-1:0] CMD_REVERSE    = 4'd9;

   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd1;
   localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd2;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_UP,
      S_UP_LAST,
      S_PUT,
      S_DN,
      S_GET,
      S_SRCH,
      S_REV_RHI,
      S_REV_WLO,
      S_REV_WHI,
      S_DONE
   } state_type;

endpackage

// File: src/iase_ram.sv
// Generic single-write, single-read memory with registered read data.
// No dependencies.
module iase_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/indexed_array_store_engine.sv
// Top level of the indexed array store engine: command sequencer, fill count
// and result register. Depends on iase_pkg and iase_ram.
//
// A dense ordered list of up to 64 signed words held in a one-write,
// one-read memory. One command beat in gives one result beat out. The block
// takes a command only while its sequencer is idle, and holds a finished
// result in an output register, so a new command may enter while the last
// result waits. All commands share the single memory port pair. Push front
// and insert move the entries from position p on up by one, walking down
// from the last entry, unless they append; pop front and remove move the
// entries above p down by one; search reads the list from entry 0 until a
// match or the end; reverse swaps pairs from both ends in a read-high,
// write-low, write-high step per pair. Entries are never cleared: only
// entries below the fill count are read, so no clearing pass follows reset.
module indexed_array_store_engine
   import iase_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // command[3:0], position[11:4], word[43:12]
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // status[2:0], read_word[34:3],
                                         // found_index[40:35], count[47:41]
);

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]    rsp_data_ff, rsp_data_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [WORD_W-1:0]   word_ff, word_in;
   logic [CNT_W-1:0]    ptr_ff, ptr_in;
   logic [ADDR_W-1:0]   wptr_ff, wptr_in;
   logic [ADDR_W-1:0]   hi_ff, hi_in;
   logic [ADDR_W-1:0]   tgt_ff, tgt_in;
   logic                first_ff, first_in;
   logic                rdv_ff, rdv_in;
   logic [WORD_W-1:0]   tmp_ff, tmp_in;
   logic [STAT_W-1:0]   status_ff, status_in;
   logic [WORD_W-1:0]   rword_ff, rword_in;
   logic [ADDR_W-1:0]   fidx_ff, fidx_in;

   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   logic [WORD_W-1:0]   mem_wdata;
   logic [ADDR_W-1:0]   mem_raddr;
   logic [WORD_W-1:0]   mem_rdata;

   logic [CMP_W-1:0]    pos_cmp;
   logic [CMP_W-1:0]    cnt_cmp;
   logic [CMP_W-1:0]    ins_cmp;
   logic [CMP_W-1:0]    rm_cmp;
   logic [CNT_W-1:0]    cnt_dec;
   logic                full;
   logic                empty;
   logic                more;

   iase_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (WORD_W),
      .AW    (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign pos_cmp = CMP_W'(pos_ff);
   assign cnt_cmp = CMP_W'(cnt_ff);
   assign ins_cmp = (cmd_ff == CMD_INSERT) ? pos_cmp : '0;
   assign rm_cmp  = (cmd_ff == CMD_REMOVE) ? pos_cmp : '0;
   assign cnt_dec = cnt_ff - 1'b1;
   assign full    = (cnt_ff == CNT_W'(CAPACITY));
   assign empty   = (cnt_ff == '0);
   assign more    = (ptr_ff < cnt_ff);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      cmd_in       = cmd_ff;
      pos_in       = pos_ff;
      word_in      = word_ff;
      ptr_in       = ptr_ff;
      wptr_in      = wptr_ff;
      hi_in        = hi_ff;
      tgt_in       = tgt_ff;
      first_in     = first_ff;
      rdv_in       = rdv_ff;
      tmp_in       = tmp_ff;
      status_in    = status_ff;
      rword_in     = rword_ff;
      fidx_in      = fidx_ff;
      mem_we       = 1'b0;
      mem_waddr    = wptr_ff;
      mem_wdata    = mem_rdata;
      mem_raddr    = ADDR_W'(ptr_ff);

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = req_tdata[3:0];
               pos_in   = req_tdata[11:4];
               word_in  = req_tdata[43:12];
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            status_in = ST_OK;
            rword_in  = '0;
            fidx_in   = '0;
            rdv_in    = 1'b0;
            first_in  = 1'b1;
            state_in  = S_DONE;
            case (cmd_ff)
               CMD_PUSH_BACK: begin
                  if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = ADDR_W'(cnt_ff);
                     mem_wdata = word_ff;
                     cnt_in    = cnt_ff + 1'b1;
                  end
               end
               CMD_PUSH_FRONT, CMD_INSERT: begin
                  if (ins_cmp > cnt_cmp) begin
                     status_in = ST_BAD_INDEX;
                  end else if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     tgt_in = ADDR_W'(ins_cmp);
                     if (ins_cmp == cnt_cmp) begin
                        state_in = S_PUT;
                     end else begin
                        ptr_in   = cnt_dec;
                        state_in = S_UP;
                     end
                  end
               end
               CMD_POP_BACK: begin
                  if (empty) begin
                     status_in = ST_EMPTY;
                  end else begin
                     mem_raddr = ADDR_W'(cnt_dec);
                     cnt_in    = cnt_dec;
                     state_in  = S_GET;
                  end
               end
               CMD_POP_FRONT, CMD_REMOVE: begin
                  if (rm_cmp >= cnt_cmp) begin
                     status_in = (cmd_ff == CMD_POP_FRONT) ? ST_EMPTY : ST_BAD_INDEX;
                  end else begin
                     mem_raddr = ADDR_W'(rm_cmp);
                     ptr_in    = CNT_W'(rm_cmp) + 1'b1;
                     wptr_in   = ADDR_W'(rm_cmp);
                     state_in  = S_DN;
                  end
               end
               CMD_GET: begin
                  if (pos_cmp >= cnt_cmp) begin
                     status_in = ST_BAD_INDEX;
                  end else begin
                     mem_raddr = ADDR_W'(pos_ff);
                     state_in  = S_GET;
                  end
               end
               CMD_SET: begin
                  if (pos_cmp >= cnt_cmp) begin
                     status_in = ST_BAD_INDEX;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = ADDR_W'(pos_ff);
                     mem_wdata = word_ff;
                  end
               end
               CMD_SEARCH: begin
                  status_in = ST_NOT_FOUND;
                  if (!empty) begin
                     ptr_in   = '0;
                     state_in = S_SRCH;
                  end
               end
               CMD_REVERSE: begin
                  if (cnt_ff > CNT_W'(1)) begin
                     mem_raddr = '0;
                     ptr_in    = '0;
                     hi_in     = ADDR_W'(cnt_dec);
                     state_in  = S_REV_RHI;
                  end
               end
               default: begin
               end
            endcase
         end
         S_UP: begin
            mem_raddr = ADDR_W'(ptr_ff);
            if (rdv_ff) begin
               mem_we    = 1'b1;
               mem_waddr = wptr_ff;
               mem_wdata = mem_rdata;
            end
            wptr_in = ADDR_W'(ptr_ff + 1'b1);
            rdv_in  = 1'b1;
            if (ptr_ff == CNT_W'(tgt_ff)) begin
               state_in = S_UP_LAST;
            end else begin
               ptr_in = ptr_ff - 1'b1;
            end
         end
         S_UP_LAST: begin
            mem_we    = 1'b1;
            mem_waddr = wptr_ff;
            mem_wdata = mem_rdata;
            state_in  = S_PUT;
         end
         S_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = tgt_ff;
            mem_wdata = word_ff;
            cnt_in    = cnt_ff + 1'b1;
            state_in  = S_DONE;
         end
         S_DN: begin
            if (more) begin
               mem_raddr = ADDR_W'(ptr_ff);
               ptr_in    = ptr_ff + 1'b1;
            end
            if (first_ff) begin
               rword_in = mem_rdata;
               first_in = 1'b0;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = wptr_ff;
               mem_wdata = mem_rdata;
               wptr_in   = wptr_ff + 1'b1;
            end
            if (!more) begin
               cnt_in   = cnt_dec;
               state_in = S_DONE;
            end
         end
         S_GET: begin
            rword_in = mem_rdata;
            state_in = S_DONE;
         end
         S_SRCH: begin
            if (more) begin
               mem_raddr = ADDR_W'(ptr_ff);
               ptr_in    = ptr_ff + 1'b1;
            end
            rdv_in = more;
            if (rdv_ff && (mem_rdata == word_ff)) begin
               status_in = ST_OK;
               fidx_in   = ADDR_W'(ptr_ff - 1'b1);
               state_in  = S_DONE;
            end else if (!more) begin
               state_in = S_DONE;
            end
         end
         S_REV_RHI: begin
            mem_raddr = hi_ff;
            tmp_in    = mem_rdata;
            state_in  = S_REV_WLO;
         end
         S_REV_WLO: begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(ptr_ff);
            mem_wdata = mem_rdata;
            state_in  = S_REV_WHI;
         end
         S_REV_WHI: begin
            mem_we    = 1'b1;
            mem_waddr = hi_ff;
            mem_wdata = tmp_ff;
            if ((ptr_ff + CNT_W'(2)) < CNT_W'(hi_ff)) begin
               mem_raddr = ADDR_W'(ptr_ff + 1'b1);
               ptr_in    = ptr_ff + 1'b1;
               hi_in     = hi_ff - 1'b1;
               state_in  = S_REV_RHI;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {COUNT_W'(cnt_ff), FIDX_W'(fidx_ff), rword_ff, status_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         first_ff     <= 1'b0;
         rdv_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         first_ff     <= first_in;
         rdv_ff       <= rdv_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      cmd_ff      <= cmd_in;
      pos_ff      <= pos_in;
      word_ff     <= word_in;
      ptr_ff      <= ptr_in;
      wptr_ff     <= wptr_in;
      hi_ff       <= hi_in;
      tgt_ff      <= tgt_in;
      tmp_ff      <= tmp_in;
      status_ff   <= status_in;
      rword_ff    <= rword_in;
      fidx_ff     <= fidx_in;
   end

`ifndef SYNTH
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CAPACITY))
      else $error("fill count above capacity");

   a_write_in_list: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (CNT_W'(mem_waddr) <= cnt_ff))
      else $error("memory write beyond the list end");

   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (cnt_ff != $past(cnt_ff))) |->
         ((cnt_ff == $past(cnt_ff) + 1'b1) || (cnt_ff + 1'b1 == $past(cnt_ff))))
      else $error("fill count moved by more than one");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> ($past(state_ff) == S_DONE))
      else $error("result raised outside the done state");
`endif

endmodule

// File: bench/indexed_array_store_engine_tb.sv
// Self-checking bench for indexed_array_store_engine: drives command beats and
// predicts every result beat from a behavioral copy of the list store.
// Depends on iase_pkg and the engine RTL.
module indexed_array_store_engine_tb
   import iase_pkg::*;
();

   localparam int CYCLE_LIMIT      = 400000;
   localparam int SETTLE_CYCLES    = 200;
   localparam int LONG_HOLD_CYCLES = 150;

   localparam logic [CMD_W-1:0] CMD_SPARE_LOW  = CMD_REVERSE + 1'b1;
   localparam logic [CMD_W-1:0] CMD_SPARE_HIGH = '1;

   typedef struct packed {
      logic [3:0]               spare;
      logic signed [WORD_W-1:0] word;
      logic [POS_W-1:0]         position;
      logic [CMD_W-1:0]         command;
   } cmd_beat_type;

   typedef struct packed {
      logic [COUNT_W-1:0]       count;
      logic [FIDX_W-1:0]        found_index;
      logic signed [WORD_W-1:0] read_word;
      logic [STAT_W-1:0]        status;
   } rsp_beat_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;   // command[3:0], position[11:4], word[43:12]
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;         // status[2:0], read_word[34:3],
                                        // found_index[40:35], count[47:41]

   logic [WORD_W-1:0] list_words [CAPACITY];
   int                list_fill = 0;
   rsp_beat_type      pending_results [$];
   int                mismatch_count = 0;
   int                cycle_count = 0;
   bit                req_idle_en = 1'b0;
   bit                rsp_idle_en = 1'b0;
   bit                long_hold_req = 1'b0;

   indexed_array_store_engine i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic rsp_beat_type apply_list_command(cmd_beat_type c);
      rsp_beat_type r;
      int        p;
      int        i;
      int        lo;
      int        hi;
      logic [WORD_W-1:0] t;
      r = '0;
      p = int'(c.position);
      case (c.command)
         CMD_PUSH_BACK: begin
            if (list_fill >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               list_words[list_fill] = c.word;
               list_fill++;
            end
         end
         CMD_PUSH_FRONT: begin
            if (list_fill >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               for (i = list_fill; i > 0; i--) list_words[i] = list_words[i-1];
               list_words[0] = c.word;
               list_fill++;
            end
         end
         CMD_INSERT: begin
            if (p > list_fill) begin
               r.status = ST_BAD_INDEX;
            end else if (list_fill >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               for (i = list_fill; i > p; i--) list_words[i] = list_words[i-1];
               list_words[p] = c.word;
               list_fill++;
            end
         end
         CMD_POP_BACK: begin
            if (list_fill == 0) begin
               r.status = ST_EMPTY;
            end else begin
               list_fill--;
               r.read_word = list_words[list_fill];
            end
         end
         CMD_POP_FRONT: begin
            if (list_fill == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.read_word = list_words[0];
               for (i = 0; i + 1 < list_fill; i++) list_words[i] = list_words[i+1];
               list_fill--;
            end
         end
         CMD_REMOVE: begin
            if (p >= list_fill) begin
               r.status = ST_BAD_INDEX;
            end else begin
               r.read_word = list_words[p];
               for (i = p; i + 1 < list_fill; i++) list_words[i] = list_words[i+1];
               list_fill--;
            end
         end
         CMD_GET: begin
            if (p >= list_fill) r.status = ST_BAD_INDEX;
            else r.read_word = list_words[p];
         end
         CMD_SET: begin
            if (p >= list_fill) r.status = ST_BAD_INDEX;
            else list_words[p] = c.word;
         end
         CMD_SEARCH: begin
            r.status = ST_NOT_FOUND;
            for (i = 0; i < list_fill; i++) begin
               if (list_words[i] == c.word) begin
                  r.status = ST_OK;
                  r.found_index = i[FIDX_W-1:0];
                  break;
               end
            end
         end
         CMD_REVERSE: begin
            lo = 0;
            hi = list_fill - 1;
            while (lo < hi) begin
               t = list_words[lo];
               list_words[lo] = list_words[hi];
               list_words[hi] = t;
               lo++;
               hi--;
            end
         end
         default: begin
         end
      endcase
      r.count = list_fill[COUNT_W-1:0];
      return r;
   endfunction

   function automatic cmd_beat_type random_list_command(int grow_weight);
      cmd_beat_type c;
      int        pick;
      c = '0;
      c.word = $urandom;
      if ($urandom_range(0, 3) == 0) c.word = $urandom_range(0, 7) - 4;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         c.command = CMD_W'($urandom_range(CMD_SPARE_LOW, CMD_SPARE_HIGH));
      end else if (pick < grow_weight) begin
         c.command = CMD_W'($urandom_range(CMD_PUSH_BACK, CMD_INSERT));
      end else begin
         c.command = CMD_W'($urandom_range(CMD_POP_BACK, CMD_REVERSE));
      end
      if ($urandom_range(0, 7) == 0) c.position = POS_W'($urandom_range(0, 255));
      else c.position = POS_W'($urandom_range(0, list_fill));
      if (c.command == CMD_SEARCH && list_fill > 0 && $urandom_range(0, 3) != 0)
         c.word = list_words[$urandom_range(0, list_fill - 1)];
      return c;
   endfunction

   task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                               input logic signed [WORD_W-1:0] word);
      cmd_beat_type c;
      c = '0;
      c.command  = cmd;
      c.position = pos;
      c.word     = word;
      if (req_idle_en && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(apply_list_command(c));
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic edge_case_test();
      send_command(CMD_POP_BACK, 0, 0);
      send_command(CMD_POP_FRONT, 0, 0);
      send_command(CMD_REMOVE, 0, 0);
      send_command(CMD_GET, 0, 0);
      send_command(CMD_SET, 0, 1);
      send_command(CMD_SEARCH, 0, 0);
      send_command(CMD_REVERSE, 0, 0);
      send_command(CMD_INSERT, 1, 7);
      send_command(CMD_INSERT, 0, 32'sh8000_0000);
      send_command(CMD_PUSH_BACK, 0, 32'sh7FFF_FFFF);
      send_command(CMD_PUSH_FRONT, 0, -1);
      send_command(CMD_INSERT, 3, 5);
      send_command(CMD_INSERT, 1, 0);
      send_command(CMD_SEARCH, 0, 5);
      send_command(CMD_PUSH_BACK, 0, 0);
      send_command(CMD_SEARCH, 0, 0);
      send_command(CMD_REVERSE, 0, 0);
      send_command(CMD_GET, 0, 0);
      send_command(CMD_GET, '1, 0);
      send_command(CMD_SET, 5, 32'sh1234_5678);
      send_command(CMD_REMOVE, 2, 0);
      send_command(CMD_REMOVE, 5, 0);
      send_command(CMD_SPARE_HIGH, '1, -1);
      send_command(CMD_SPARE_LOW, 0, 0);
      send_command(CMD_REVERSE, 0, 0);
      send_command(CMD_POP_FRONT, 0, 0);
      send_command(CMD_POP_BACK, 0, 0);
   endtask

   task automatic full_store_test();
      cmd_beat_type c;
      while (list_fill < CAPACITY) begin
         c = random_list_command(100);
         if (c.command > CMD_INSERT) c.command = CMD_PUSH_BACK;
         c.position = POS_W'($urandom_range(0, list_fill));
         send_command(c.command, c.position, c.word);
      end
      send_command(CMD_PUSH_BACK, 0, 1);
      send_command(CMD_PUSH_FRONT, 0, 2);
      send_command(CMD_INSERT, POS_W'(CAPACITY), 3);
      send_command(CMD_INSERT, '1, 4);
      send_command(CMD_SEARCH, 0, list_words[CAPACITY-1]);
      send_command(CMD_REVERSE, 0, 0);
      send_command(CMD_GET, POS_W'(CAPACITY - 1), 0);
      send_command(CMD_SET, POS_W'(CAPACITY - 1), $urandom);
      send_command(CMD_REMOVE, POS_W'(CAPACITY), 0);
      while (list_fill > 1) begin
         c.command  = CMD_W'($urandom_range(CMD_POP_BACK, CMD_REMOVE));
         c.position = POS_W'($urandom_range(0, list_fill - 1));
         send_command(c.command, c.position, $urandom);
      end
      send_command(CMD_REVERSE, 0, 0);
      send_command(CMD_POP_BACK, 0, 0);
      send_command(CMD_POP_BACK, 0, 0);
   endtask

   task automatic backpressure_test();
      cmd_beat_type c;
      int        n;
      req_idle_en   = 1'b0;
      long_hold_req = 1'b1;
      for (n = 0; n < 12; n++) begin
         c = random_list_command(60);
         send_command(c.command, c.position, c.word);
      end
      wait_for_results();
   endtask

   task automatic random_mix_test(input int items, input int grow_weight, input bit idle);
      cmd_beat_type c;
      int        n;
      req_idle_en = idle;
      rsp_idle_en = idle;
      for (n = 0; n < items; n++) begin
         c = random_list_command(grow_weight);
         send_command(c.command, c.position, c.word);
      end
   endtask

   initial begin : rsp_pacing
      int hold_left;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            hold_left = LONG_HOLD_CYCLES;
            while (hold_left > 0) begin
               @(posedge clock);
               hold_left--;
            end
            rsp_tready <= 1'b1;
         end else if (rsp_idle_en && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_beat_type seen;
      rsp_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_tdata;
         if (pending_results.size() == 0) begin
            $error("result beat with no command outstanding: %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (seen.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, seen.status);
               mismatch_count++;
            end
            if (seen.read_word !== want.read_word) begin
               $error("read_word: expected %0d, got %0d", want.read_word, seen.read_word);
               mismatch_count++;
            end
            if (seen.found_index !== want.found_index) begin
               $error("found_index: expected %0d, got %0d",
                      want.found_index, seen.found_index);
               mismatch_count++;
            end
            if (seen.count !== want.count) begin
               $error("count: expected %0d, got %0d", want.count, seen.count);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
      edge_case_test();
      full_store_test();
      backpressure_test();
      random_mix_test(120, 55, 1'b1);
      random_mix_test(100, 30, 1'b1);
      random_mix_test(80, 45, 1'b0);
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: indexed_array_store_engine.f
src/iase_pkg.sv
src/iase_ram.sv
src/indexed_array_store_engine.sv
bench/indexed_array_store_engine_tb.sv
